### hw/rtl/lal_pkg.sv
// Shared constants for the least-loaded assignment block.
`timescale 1ns / 1ps
`default_nettype none

package lal_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int LOAD_BITS_DEF = 40;

  localparam int CELLS_W  = 24;
  localparam int RANK_W   = 4;
  localparam int ACTIVE_W = 5;
  localparam int LIDX_W   = 16;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MY_RANK      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PROCS = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

endpackage

`default_nettype wire

### hw/rtl/least_loaded_assignment.sv
// Top level: greedy least-loaded assignment of work items to processors.
//
// Each accepted beat carries one item's cell count. The block scans the stored
// load of every active processor, one memory read per cycle, picks the lowest
// index with the smallest load, adds the count (saturating) and returns one
// result beat. An item occupies the block from acceptance through the scan to
// its update; it takes no new item meanwhile, as the load memory has a single
// read port for the scan. A pending result in the output register does
// not stop the next item from being accepted, but that item holds in its
// update cycle until the result beat is taken. first_of_run clears every load
// and the local index counter in the cycle of acceptance; the load valid bits
// clear on reset, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_assignment #(
  parameter int MAX_PROCS = lal_pkg::MAX_PROCS_DEF,
  parameter int LOAD_BITS = lal_pkg::LOAD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lal_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lal_pkg::CELLS_W-1:0]    item_cells,
  input  wire logic                           first_of_run,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [lal_pkg::RANK_W-1:0]     target_proc,
  output logic                                is_mine,
  output logic      [lal_pkg::LIDX_W-1:0]     local_index,
  output logic                                load_saturated
);

  localparam int PIDX_W = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_A  = $clog2(MAX_PROCS + 1);
  localparam int CNT_W  = (CNT_A > lal_pkg::ACTIVE_W) ? CNT_A : lal_pkg::ACTIVE_W;
  localparam int RW     = (PIDX_W > lal_pkg::RANK_W) ? PIDX_W : lal_pkg::RANK_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t                         state;
  logic [lal_pkg::RANK_W-1:0]     my_rank;
  logic [lal_pkg::ACTIVE_W-1:0]   active_procs;
  logic [lal_pkg::CELLS_W-1:0]    cells_q;
  logic [lal_pkg::LIDX_W-1:0]     own_count;
  logic [CNT_W-1:0]               issue_idx;
  logic [CNT_W-1:0]               data_idx;
  logic [PIDX_W-1:0]              best_idx;
  logic [LOAD_BITS-1:0]           best_load;

  logic                           accept;
  logic                           clear;
  logic [CNT_W-1:0]               act_ext;
  logic [CNT_W-1:0]               n_act;
  logic                           last;
  logic [PIDX_W-1:0]              rd_addr;
  logic [LOAD_BITS-1:0]           rd_load;
  logic                           take;
  logic [LOAD_BITS:0]             sum;
  logic                           sat;
  logic [LOAD_BITS-1:0]           new_load;
  logic [RW-1:0]                  best_ext;
  logic                           mine;
  logic                           out_free;
  logic                           wr_en;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign clear    = accept && first_of_run;

  // Active count clamped to 1..MAX_PROCS
  always_comb begin
    act_ext = CNT_W'(active_procs);
    n_act   = act_ext;
    if (act_ext == '0) begin
      n_act = CNT_W'(1);
    end else if (act_ext > CNT_W'(MAX_PROCS)) begin
      n_act = CNT_W'(MAX_PROCS);
    end
  end

  assign last    = (data_idx == n_act - CNT_W'(1));
  assign rd_addr = (state == S_IDLE) ? '0 : issue_idx[PIDX_W-1:0];
  assign take    = (data_idx == '0) || (rd_load < best_load);

  assign sum      = {1'b0, best_load} + (LOAD_BITS + 1)'(cells_q);
  assign sat      = sum[LOAD_BITS];
  assign new_load = sat ? '1 : sum[LOAD_BITS-1:0];
  assign best_ext = RW'(best_idx);
  assign mine     = (best_ext == RW'(my_rank));
  assign out_free = !out_valid || out_ready;
  assign wr_en    = (state == S_UPDATE) && out_free;

  lal_load_mem #(
    .MAX_PROCS (MAX_PROCS),
    .LOAD_BITS (LOAD_BITS),
    .PIDX_W    (PIDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .rd_addr (rd_addr),
    .rd_load (rd_load),
    .wr_en   (wr_en),
    .wr_addr (best_idx),
    .wr_data (new_load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      my_rank      <= '0;
      active_procs <= lal_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lal_pkg::REG_MY_RANK:      my_rank      <= cfg_data[lal_pkg::RANK_W-1:0];
        lal_pkg::REG_ACTIVE_PROCS: active_procs <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      own_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (first_of_run) begin
              own_count <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // Hold until the output register is free
          if (out_free) begin
            if (mine) begin
              own_count <= own_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cells_q   <= item_cells;
          issue_idx <= CNT_W'(1);
          data_idx  <= '0;
        end
      end
      S_SCAN: begin
        if (take) begin
          best_idx  <= data_idx[PIDX_W-1:0];
          best_load <= rd_load;
        end
        issue_idx <= issue_idx + CNT_W'(1);
        data_idx  <= data_idx + CNT_W'(1);
      end
      S_UPDATE: begin
        if (out_free) begin
          target_proc    <= best_ext[lal_pkg::RANK_W-1:0];
          is_mine        <= mine;
          local_index    <= mine ? own_count : '0;
          load_saturated <= sat;
        end
      end
      default: ;
    endcase
  end

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN))
    else $error("accepted item did not start a scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> (CNT_W'(best_idx) < n_act))
    else $error("chosen processor outside the active set");

  a_mine_rank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_mine) |-> (target_proc == my_rank))
    else $error("own item reported for another processor");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_mine) |-> (local_index == '0))
    else $error("local index set on a foreign item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && mine && !clear) |=> (own_count == $past(own_count) + 1'b1))
    else $error("own counter did not advance");

endmodule

`default_nettype wire

### hw/rtl/lal_load_mem.sv
// Per-processor load memory with registered read and valid bits for run clearing.
`timescale 1ns / 1ps
`default_nettype none

module lal_load_mem #(
  parameter int MAX_PROCS = lal_pkg::MAX_PROCS_DEF,
  parameter int LOAD_BITS = lal_pkg::LOAD_BITS_DEF,
  parameter int PIDX_W    = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic [PIDX_W-1:0]    rd_addr,
  output logic      [LOAD_BITS-1:0] rd_load,
  input  wire logic                 wr_en,
  input  wire logic [PIDX_W-1:0]    wr_addr,
  input  wire logic [LOAD_BITS-1:0] wr_data
);

  logic [LOAD_BITS-1:0] mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] vld;
  logic [LOAD_BITS-1:0] rd_q;
  logic                 rd_vq;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A clear on the same edge wins over the old valid bit
  always_ff @(posedge clk) begin
    rd_q  <= mem[rd_addr];
    rd_vq <= vld[rd_addr] & ~clear;
  end

  assign rd_load = rd_vq ? rd_q : '0;

endmodule

`default_nettype wire
